// ----- hw/rtl/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and tables for the tune string tone sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

	// Divider geometry: widest dividend is the timer clock, widest divisor a frequency
	localparam int DIV_W     = 21;
	localparam int DVS_W     = 15;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [DIV_W-1:0] DUR_NUM   = DIV_W'(240000);
	localparam logic [DIV_W-1:0] TIMER_CLK = DIV_W'(1193180);
	localparam logic [DVS_W-1:0] FREQ_FLOOR = DVS_W'(523);

	localparam logic [9:0]  LENGTH_LIMIT = 10'd999;
	localparam logic [3:0]  DOT_LIMIT    = 4'd15;
	localparam logic [23:0] MAX24        = 24'hFFFFFF;

	// Result kinds
	localparam logic [1:0] EV_TONE = 2'd0;
	localparam logic [1:0] EV_REST = 2'd1;
	localparam logic [1:0] EV_ERR  = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_TEMPO = 2'd0;
	localparam logic [1:0] REG_DLEN  = 2'd1;
	localparam logic [1:0] REG_OCT   = 2'd2;
	localparam logic [1:0] REG_ART   = 2'd3;

	// Articulation codes
	localparam logic [1:0] ART_STACCATO = 2'd1;
	localparam logic [1:0] ART_LEGATO   = 2'd2;

	// Parse phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_NOTE = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;
	localparam logic [1:0] PH_DOT  = 2'd3;

	// Divider operand selects
	localparam logic [1:0] DSEL_LEN   = 2'd0;
	localparam logic [1:0] DSEL_TEMPO = 2'd1;
	localparam logic [1:0] DSEL_FREQ  = 2'd2;

	// Top-octave base frequencies, worked out at elaboration
	localparam logic [13:0] PB0  = 14'(64'd4050816000 / 64'd483852);
	localparam logic [13:0] PB1  = 14'(64'd4050816000 / 64'd456695);
	localparam logic [13:0] PB2  = 14'(64'd4050816000 / 64'd431063);
	localparam logic [13:0] PB3  = 14'(64'd4050816000 / 64'd406869);
	localparam logic [13:0] PB4  = 14'(64'd4050816000 / 64'd384033);
	localparam logic [13:0] PB5  = 14'(64'd4050816000 / 64'd362479);
	localparam logic [13:0] PB6  = 14'(64'd4050816000 / 64'd342135);
	localparam logic [13:0] PB7  = 14'(64'd4050816000 / 64'd322932);
	localparam logic [13:0] PB8  = 14'(64'd4050816000 / 64'd304808);
	localparam logic [13:0] PB9  = 14'(64'd4050816000 / 64'd287700);
	localparam logic [13:0] PB10 = 14'(64'd4050816000 / 64'd271553);
	localparam logic [13:0] PB11 = 14'(64'd4050816000 / 64'd256312);

	typedef struct packed {
		logic [7:0] tempo;
		logic [6:0] dlen;
		logic [2:0] oct;
		logic [1:0] art;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       clear_pend;
		logic       apply;
		logic       set_halt;
		logic       clr_halt;
		logic       div_start;
		logic [1:0] div_sel;
		logic       take_quot;
		logic       dot_step;
		logic       out_load;
		logic       out_err;
		logic       out_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic halted;
		logic last;
		logic phase_nz;
		logic is_note;
		logic c_err;
		logic needs_flush;
		logic more_after;
		logic dots_nz;
		logic div_busy;
		logic out_free;
	} stat_t;

	function automatic logic [13:0] pitch_base(input logic [3:0] s);
		logic [13:0] r;
		case (s)
			4'd0:    r = PB0;
			4'd1:    r = PB1;
			4'd2:    r = PB2;
			4'd3:    r = PB3;
			4'd4:    r = PB4;
			4'd5:    r = PB5;
			4'd6:    r = PB6;
			4'd7:    r = PB7;
			4'd8:    r = PB8;
			4'd9:    r = PB9;
			4'd10:   r = PB10;
			default: r = PB11;
		endcase
		return r;
	endfunction

	// Semitone of letters A..G, index is letter minus 'A'
	function automatic logic [3:0] letter_semi(input logic [2:0] l);
		logic [3:0] r;
		case (l)
			3'd0:    r = 4'd9;
			3'd1:    r = 4'd11;
			3'd2:    r = 4'd0;
			3'd3:    r = 4'd2;
			3'd4:    r = 4'd4;
			3'd5:    r = 4'd5;
			default: r = 4'd7;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/tss_div.sv -----
// ----------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tss_div import tss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);

	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DVS_W:0]       trial;
	logic                 fit;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != DIV_CNT_W'(1);
		end
	end

	// shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/tss_datapath.sv -----
// ----------------------------------------------------------------------------
// tss_datapath
// Parser state, duration and pitch arithmetic, and the result register.
// ----------------------------------------------------------------------------
module tss_datapath import tss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [7:0]  in_char,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [15:0] out_div,
	output logic [23:0] out_snd,
	output logic [23:0] out_sil,
	output logic        out_last
);

	logic [7:0]  char_q;
	logic        last_q;
	logic [1:0]  phase_q;
	logic        is_note_q;
	logic [6:0]  note_q;
	logic [9:0]  len_q;
	logic [3:0]  dots_q;
	logic        halted_q;
	logic [23:0] t_q;
	logic        ov_q;
	logic [1:0]  okind_q;
	logic [15:0] odiv_q;
	logic [23:0] osnd_q;
	logic [23:0] osil_q;
	logic        olast_q;

	// character classes
	logic [7:0] up;
	logic       c_letter, c_pause, c_space, c_sharp, c_flat, c_digit, c_dot, c_err;

	always_comb begin
		up       = (char_q >= "a" && char_q <= "z") ? char_q - 8'd32 : char_q;
		c_letter = up >= "A" && up <= "G";
		c_pause  = up == "P";
		c_space  = char_q == " " || (char_q >= 8'd9 && char_q <= 8'd13);
		c_sharp  = phase_q == PH_NOTE && (char_q == "#" || char_q == "+");
		c_flat   = phase_q == PH_NOTE && char_q == "-";
		c_digit  = (phase_q == PH_NOTE || phase_q == PH_LEN) && char_q >= "0" && char_q <= "9";
		c_dot    = phase_q != PH_IDLE && char_q == ".";
		c_err    = !(c_letter || c_pause || c_space || c_sharp || c_flat || c_digit || c_dot);
	end

	// next values of the parse fields
	logic [3:0]  semi;
	logic [6:0]  note_new;
	logic [13:0] len_x10;
	always_comb begin
		semi     = letter_semi(3'(up - "A"));
		note_new = 7'({cfg.oct, 3'b0}) + 7'({cfg.oct, 2'b0}) + 7'(semi);
		len_x10  = 14'({len_q, 3'b0}) + 14'({len_q, 1'b0}) + 14'(char_q - "0");
	end

	// pitch: octave = n/12 by reciprocal, then shift the base frequency
	logic [12:0]      n43;
	logic [3:0]       octv;
	logic [3:0]       sem;
	logic [13:0]      base;
	logic [DVS_W-1:0] freq;
	always_comb begin
		n43  = 13'(note_q) * 13'd43;
		octv = n43[12:9];
		sem  = 4'(note_q - 7'({octv, 3'b0}) - 7'({octv, 2'b0}));
		base = pitch_base(sem);
		if (octv <= 4'd7)
			freq = DVS_W'(base >> (3'd7 - octv[2:0]));
		else
			freq = DVS_W'({base, 1'b0});
		if (freq == '0)
			freq = FREQ_FLOOR;
	end

	// divider operands
	logic [DIV_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic [9:0]       len_eff;
	logic [DIV_W-1:0] quot;
	logic             div_busy;
	always_comb begin
		len_eff = len_q != '0 ? len_q : 10'(cfg.dlen);
		if (len_eff == '0)
			len_eff = 10'd1;
		case (cmd.div_sel)
			DSEL_LEN: begin
				dvd = DUR_NUM;
				dvs = DVS_W'(len_eff);
			end
			DSEL_TEMPO: begin
				dvd = quot;
				dvs = cfg.tempo != '0 ? DVS_W'(cfg.tempo) : DVS_W'(1);
			end
			default: begin
				dvd = TIMER_CLK;
				dvs = freq;
			end
		endcase
	end

	tss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.quotient (quot)
	);

	// dotted extension and articulation split
	logic [24:0] t_dot;
	logic [23:0] sil;
	always_comb begin
		t_dot = 25'(t_q) + 25'(t_q[23:1]);
		case (cfg.art)
			ART_STACCATO: sil = {2'b0, t_q[23:2]};
			ART_LEGATO:   sil = '0;
			default:      sil = {3'b0, t_q[23:3]};
		endcase
	end

	// input capture and duration register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			char_q <= in_char;
			last_q <= in_last;
		end
		if (cmd.take_quot)
			t_q <= 24'(quot);
		else if (cmd.dot_step)
			t_q <= t_dot > 25'(MAX24) ? MAX24 : t_dot[23:0];
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			is_note_q <= 1'b0;
			note_q    <= '0;
			len_q     <= '0;
			dots_q    <= '0;
			halted_q  <= 1'b0;
		end else begin
			if (cmd.clear_pend) begin
				phase_q   <= PH_IDLE;
				is_note_q <= 1'b0;
				note_q    <= '0;
				len_q     <= '0;
				dots_q    <= '0;
			end else if (cmd.dot_step) begin
				dots_q <= dots_q - 1'b1;
			end else if (cmd.apply) begin
				if (c_letter) begin
					note_q    <= note_new;
					is_note_q <= 1'b1;
					phase_q   <= PH_NOTE;
				end else if (c_pause) begin
					is_note_q <= 1'b0;
					phase_q   <= PH_LEN;
				end else if (c_sharp) begin
					note_q  <= note_q + 1'b1;
					phase_q <= PH_LEN;
				end else if (c_flat) begin
					if (note_q != '0)
						note_q <= note_q - 1'b1;
					phase_q <= PH_LEN;
				end else if (c_digit) begin
					len_q   <= len_x10 > 14'(LENGTH_LIMIT) ? LENGTH_LIMIT : len_x10[9:0];
					phase_q <= PH_LEN;
				end else if (c_dot) begin
					if (dots_q != DOT_LIMIT)
						dots_q <= dots_q + 1'b1;
					phase_q <= PH_DOT;
				end
			end
			if (cmd.set_halt)
				halted_q <= 1'b1;
			else if (cmd.clr_halt)
				halted_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.out_load)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			olast_q <= cmd.out_last;
			if (cmd.out_err) begin
				okind_q <= EV_ERR;
				odiv_q  <= '0;
				osnd_q  <= '0;
				osil_q  <= '0;
			end else if (is_note_q) begin
				okind_q <= EV_TONE;
				odiv_q  <= quot[15:0];
				osnd_q  <= t_q - sil;
				osil_q  <= sil;
			end else begin
				okind_q <= EV_REST;
				odiv_q  <= '0;
				osnd_q  <= '0;
				osil_q  <= t_q;
			end
		end
	end

	always_comb begin
		stat.halted      = halted_q;
		stat.last        = last_q;
		stat.phase_nz    = phase_q != PH_IDLE;
		stat.is_note     = is_note_q;
		stat.c_err       = c_err;
		stat.needs_flush = phase_q != PH_IDLE && (c_letter || c_pause || c_space || c_err);
		stat.more_after  = c_err || (last_q && (c_letter || c_pause));
		stat.dots_nz     = dots_q != '0;
		stat.div_busy    = div_busy;
		stat.out_free    = !ov_q || out_ready;
	end

	assign out_valid = ov_q;
	assign out_kind  = okind_q;
	assign out_div   = odiv_q;
	assign out_snd   = osnd_q;
	assign out_sil   = osil_q;
	assign out_last  = olast_q;

endmodule

// ----- hw/rtl/tss_ctrl.sv -----
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: decode, flush, divide, dot, emit and apply steps for one character.
// ----------------------------------------------------------------------------
module tss_ctrl import tss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_DLEN  = 4'd2;
	localparam logic [3:0] ST_DTMP  = 4'd3;
	localparam logic [3:0] ST_DOTS  = 4'd4;
	localparam logic [3:0] ST_DFRQ  = 4'd5;
	localparam logic [3:0] ST_EMIT  = 4'd6;
	localparam logic [3:0] ST_APPLY = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0] st_q, st_d;
	logic       post_q, post_d;

	always_comb begin
		st_d   = st_q;
		post_d = post_q;
		cmd    = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					st_d        = ST_DEC;
				end
			end
			ST_DEC: begin
				if (stat.halted) begin
					if (stat.last) begin
						cmd.clr_halt   = 1'b1;
						cmd.clear_pend = 1'b1;
					end
					st_d = ST_IDLE;
				end else if (stat.needs_flush) begin
					post_d        = 1'b0;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_LEN;
					st_d          = ST_DLEN;
				end else begin
					st_d = ST_APPLY;
				end
			end
			ST_DLEN: begin
				if (!stat.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_TEMPO;
					st_d          = ST_DTMP;
				end
			end
			ST_DTMP: begin
				if (!stat.div_busy) begin
					cmd.take_quot = 1'b1;
					st_d          = ST_DOTS;
				end
			end
			ST_DOTS: begin
				if (stat.dots_nz) begin
					cmd.dot_step = 1'b1;
				end else if (stat.is_note) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_FREQ;
					st_d          = ST_DFRQ;
				end else begin
					st_d = ST_EMIT;
				end
			end
			ST_DFRQ: begin
				cmd.div_sel = DSEL_FREQ;
				if (!stat.div_busy)
					st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = post_q || !stat.more_after;
					cmd.clear_pend = 1'b1;
					st_d           = post_q ? ST_IDLE : ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (stat.c_err) begin
					if (stat.out_free) begin
						cmd.out_load   = 1'b1;
						cmd.out_err    = 1'b1;
						cmd.out_last   = 1'b1;
						cmd.clear_pend = 1'b1;
						cmd.set_halt   = !stat.last;
						st_d           = ST_IDLE;
					end
				end else begin
					cmd.apply = 1'b1;
					st_d      = ST_FIN;
				end
			end
			ST_FIN: begin
				// end of tune: flush whatever is still pending
				if (stat.last && stat.phase_nz) begin
					post_d        = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_LEN;
					st_d          = ST_DLEN;
				end else begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			post_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			post_q <= post_d;
		end
	end

	assign in_ready = st_q == ST_IDLE;

endmodule

// ----- hw/rtl/tune_string_tone_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// tune_string_tone_sequencer_core
// Turns tune text, one character per beat, into tone, rest and error commands.
// ----------------------------------------------------------------------------
// One character is taken at a time. A character that only extends the pending
// note (accidental, digit, dot) passes through the decode, apply and finish
// steps. One that issues a note or rest runs divisions on the shared restoring
// divider (length, tempo, timer divisor; rests skip the last), plus one dot
// step per dot. When end of tune flushes a second note, that note runs its own
// divisions as well. Any wait for the output register to drain lengthens this
// work. The next character is taken while the last result waits at the output.
// ----------------------------------------------------------------------------
module tune_string_tone_sequencer_core import tss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] tune_char
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] timer_divisor, [39:16] sound_ms, [63:40] silence_ms
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg_q;
	cmd_t        cmd;
	stat_t       stat;
	logic [1:0]  ridx;
	logic [15:0] odiv;
	logic [23:0] osnd, osil;

	assign pready = 1'b1;
	assign ridx   = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tempo <= 8'd120;
			cfg_q.dlen  <= 7'd4;
			cfg_q.oct   <= 3'd3;
			cfg_q.art   <= 2'd0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_TEMPO: cfg_q.tempo <= pwdata[7:0];
				REG_DLEN:  cfg_q.dlen  <= pwdata[6:0];
				REG_OCT:   cfg_q.oct   <= pwdata[2:0];
				REG_ART:   cfg_q.art   <= pwdata[1:0];
				default:   ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		case (ridx)
			REG_TEMPO: prdata = 32'(cfg_q.tempo);
			REG_DLEN:  prdata = 32'(cfg_q.dlen);
			REG_OCT:   prdata = 32'(cfg_q.oct);
			REG_ART:   prdata = 32'(cfg_q.art);
			default:   prdata = '0;
		endcase
	end

	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tss_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.stat      (stat),
		.in_char   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_div   (odiv),
		.out_snd   (osnd),
		.out_sil   (osil),
		.out_last  (m_tlast)
	);

	assign m_tdata = {osil, osnd, odiv};

	// one character in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second character taken while one is in work");

	// the divider is always finished before a new character is taken
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.div_busy)
		else $error("divider busy while waiting for input");

	// a result is only loaded when the output register has room
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over one not yet taken");

endmodule

// ----- sim/tone_cmd_checker.sv -----
// ----------------------------------------------------------------------------
// tone_cmd_checker
// Watches the character, command and register ports of the tune sequencer,
// parses the tune text itself and checks every command beat in order.
// ----------------------------------------------------------------------------
module tone_cmd_checker import tss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          cmds_due,
	output int          cmds_checked
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] divisor;
		logic [23:0] sound;
		logic [23:0] silence;
		logic        last;
	} tone_cmd_t;

	// Pitch factors per semitone, C first
	localparam int unsigned PITCH_FACTOR [12] = '{483852, 456695, 431063, 406869,
		384033, 362479, 342135, 322932, 304808, 287700, 271553, 256312};

	tone_cmd_t tone_cmds_due [$];
	tone_cmd_t fresh [$];

	// Register copies
	logic [7:0] tempo;
	logic [6:0] dlen;
	logic [2:0] octave;
	logic [1:0] artic;

	// Parser state
	logic [1:0] phase;
	logic       is_note;
	logic [6:0] note;
	logic [9:0] len_acc;
	logic [3:0] dots;
	logic       halted;

	function automatic logic [15:0] timer_count(input logic [6:0] n);
		longint unsigned base, freq;
		int unsigned     oct;
		oct  = n / 12;
		base = 64'd4050816000 / PITCH_FACTOR[n % 12];
		if (oct <= 7)
			freq = base >> (7 - oct);
		else
			freq = (base << 1) & 64'hFFFF;
		if (freq == 0)
			freq = 523;
		return 16'(64'd1193180 / freq);
	endfunction

	function automatic int letter_to_semi(input logic [7:0] idx);
		case (idx)
			0:       return 9;
			1:       return 11;
			2:       return 0;
			3:       return 2;
			4:       return 4;
			5:       return 5;
			default: return 7;
		endcase
	endfunction

	task automatic clear_pending();
		phase   = PH_IDLE;
		is_note = 1'b0;
		note    = '0;
		len_acc = '0;
		dots    = '0;
	endtask

	// Issue the pending note or pause, if any
	task automatic issue_pending();
		longint unsigned t, sil, len, bpm;
		tone_cmd_t c;
		if (phase == PH_IDLE)
			return;
		len = (len_acc != 0) ? len_acc : dlen;
		if (len == 0)
			len = 1;
		bpm = (tempo != 0) ? tempo : 1;
		t = 240000 / len / bpm;
		for (int i = 0; i < dots; i++) begin
			t = t * 3 / 2;
			if (t > MAX24)
				t = MAX24;
		end
		if (artic == ART_STACCATO)
			sil = t / 4;
		else if (artic == ART_LEGATO)
			sil = 0;
		else
			sil = t / 8;
		c = '0;
		if (is_note) begin
			c.kind    = EV_TONE;
			c.divisor = timer_count(note);
			c.sound   = 24'(t - sil);
			c.silence = 24'(sil);
		end else begin
			c.kind    = EV_REST;
			c.silence = 24'(t);
		end
		fresh.push_back(c);
		clear_pending();
	endtask

	task automatic parse_char(input logic [7:0] ch, input logic fin);
		logic [7:0] up;
		int unsigned v;
		tone_cmd_t e;
		fresh.delete();
		up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		if (halted) begin
			if (fin) begin
				halted = 1'b0;
				clear_pending();
			end
			return;
		end
		if (up >= "A" && up <= "G") begin
			issue_pending();
			note    = 7'(letter_to_semi(up - "A") + octave * 12);
			is_note = 1'b1;
			phase   = PH_NOTE;
		end else if (up == "P") begin
			issue_pending();
			is_note = 1'b0;
			phase   = PH_LEN;
		end else if (ch == " " || (ch >= 9 && ch <= 13)) begin
			issue_pending();
		end else if (phase == PH_NOTE && (ch == "#" || ch == "+")) begin
			note  = note + 7'd1;
			phase = PH_LEN;
		end else if (phase == PH_NOTE && ch == "-") begin
			if (note != 0)
				note = note - 7'd1;
			phase = PH_LEN;
		end else if ((phase == PH_NOTE || phase == PH_LEN) && ch >= "0" && ch <= "9") begin
			v       = len_acc * 10 + (ch - "0");
			len_acc = (v > LENGTH_LIMIT) ? LENGTH_LIMIT : 10'(v);
			phase   = PH_LEN;
		end else if (phase != PH_IDLE && ch == ".") begin
			if (dots < DOT_LIMIT)
				dots = dots + 4'd1;
			phase = PH_DOT;
		end else begin
			issue_pending();
			e      = '0;
			e.kind = EV_ERR;
			fresh.push_back(e);
			clear_pending();
			halted = 1'b1;
		end
		if (fin) begin
			issue_pending();
			clear_pending();
			halted = 1'b0;
		end
		if (fresh.size() > 0)
			fresh[fresh.size()-1].last = 1'b1;
		foreach (fresh[i])
			tone_cmds_due.push_back(fresh[i]);
	endtask

	// Compare one command beat with the oldest prediction
	task automatic check_beat();
		tone_cmd_t got, want;
		got.kind    = m_tuser;
		got.divisor = m_tdata[15:0];
		got.sound   = m_tdata[39:16];
		got.silence = m_tdata[63:40];
		got.last    = m_tlast;
		cmds_checked++;
		if (tone_cmds_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("[%0t] unexpected beat kind=%0d div=%0d snd=%0d sil=%0d last=%0d",
					$realtime, got.kind, got.divisor, got.sound, got.silence, got.last);
			return;
		end
		want = tone_cmds_due.pop_front();
		if (got.kind != want.kind || got.divisor != want.divisor || got.sound != want.sound ||
				got.silence != want.silence || got.last != want.last) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("[%0t] mismatch exp kind=%0d div=%0d snd=%0d sil=%0d last=%0d",
					$realtime, want.kind, want.divisor, want.sound, want.silence,
					want.last);
				$display("         got kind=%0d div=%0d snd=%0d sil=%0d last=%0d",
					got.kind, got.divisor, got.sound, got.silence, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo  = 8'd120;
			dlen   = 7'd4;
			octave = 3'd3;
			artic  = 2'd0;
			halted = 1'b0;
			clear_pending();
			fail_count   = 0;
			cmds_checked = 0;
			tone_cmds_due.delete();
			cmds_due = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_TEMPO: tempo  = pwdata[7:0];
					REG_DLEN:  dlen   = pwdata[6:0];
					REG_OCT:   octave = pwdata[2:0];
					REG_ART:   artic  = pwdata[1:0];
					default:   ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				parse_char(s_tdata, s_tlast);
			cmds_due = tone_cmds_due.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives tune text and register settings into the tune sequencer; the
// command checker beside it predicts and compares every command beat.
// ----------------------------------------------------------------------------
module tb import tss_pkg::*; ();

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN       = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] tune_char
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [15:0] timer_divisor, [39:16] sound_ms, [63:40] silence_ms
	logic [1:0]  m_tuser;   // [1:0] event_kind
	logic        m_tlast;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	int fail_count, cmds_due, cmds_checked;
	int chars_sent;
	int cycles;
	bit idle_on;
	bit stall_rx;

	tune_string_tone_sequencer_core dut (.*);

	tone_cmd_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .cmds_due, .cmds_checked
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Command sink: random idling plus one long hold-off
	always @(posedge clk) begin
		if (stall_rx)
			m_tready <= 1'b0;
		else if (idle_on)
			m_tready <= ($urandom_range(99) >= 6);
		else
			m_tready <= 1'b1;
	end

	initial begin
		stall_rx = 1'b0;
		wait (chars_sent >= 500);
		@(posedge clk);
		stall_rx <= 1'b1;
		repeat (600) @(posedge clk);
		stall_rx <= 1'b0;
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] ch, input logic fin);
		int unsigned gap;
		if (idle_on && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	task automatic send_text(input string txt, input bit fin);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i], fin && (i == txt.len() - 1));
	endtask

	// Drain the command stream, then give the block time to settle
	task automatic settle();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (cmds_due != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic add_length(ref logic [7:0] tq [$]);
		int unsigned nd;
		nd = ($urandom_range(19) == 0) ? 5 : $urandom_range(0, 3);
		for (int i = 0; i < nd; i++)
			tq.push_back(8'("0" + $urandom_range(9)));
		nd = ($urandom_range(29) == 0) ? 17 : $urandom_range(0, 2);
		for (int i = 0; i < nd; i++)
			tq.push_back(".");
	endtask

	// Mostly well-formed tunes, with some noise and misplaced marks
	task automatic make_tune(ref logic [7:0] tq [$]);
		int unsigned ntok, r;
		ntok = $urandom_range(1, 8);
		for (int k = 0; k < ntok; k++) begin
			r = $urandom_range(99);
			if (r < 60) begin
				tq.push_back(8'(($urandom_range(1) ? "A" : "a") + $urandom_range(6)));
				case ($urandom_range(5))
					0: tq.push_back("#");
					1: tq.push_back("+");
					2: tq.push_back("-");
					default: ;
				endcase
				add_length(tq);
			end else if (r < 75) begin
				tq.push_back($urandom_range(1) ? "P" : "p");
				add_length(tq);
			end else if (r < 85) begin
				tq.push_back($urandom_range(1) ? " " : 8'($urandom_range(9, 13)));
			end else if (r < 93) begin
				tq.push_back(8'($urandom_range(255)));
			end else begin
				case ($urandom_range(3))
					0: tq.push_back("#");
					1: tq.push_back("-");
					2: tq.push_back(".");
					default: tq.push_back(8'("0" + $urandom_range(9)));
				endcase
			end
		end
	endtask

	task automatic random_tunes(input int n_chars);
		logic [7:0] tq [$];
		int stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			tq.delete();
			make_tune(tq);
			foreach (tq[i])
				send_char(tq[i], i == tq.size() - 1);
		end
	endtask

	task automatic set_regs(input int bpm, input int dl, input int oc, input int ar);
		reg_write(REG_TEMPO, bpm);
		reg_write(REG_DLEN, dl);
		reg_write(REG_OCT, oc);
		reg_write(REG_ART, ar);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		chars_sent = 0;
		idle_on  = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, every letter, accidentals, lengths, errors
		send_text("cD#4. e+16..", 0);
		send_text("p8 a12345 g0", 1);
		send_text("fx", 0);
		send_text("b2", 0);
		send_text("c", 1);
		send_text("#", 1);
		send_char(8'd0, 1);
		send_char(8'd9, 0);
		send_char(8'hFF, 1);
		settle();

		// Extremes at the low end, flat on the lowest note
		set_regs(1, 1, 0, 0);
		send_text("C-", 1);
		random_tunes(230);
		settle();

		// Extremes at the high end, with the long hold-off on the sink
		set_regs(255, 64, 6, 2);
		random_tunes(260);
		settle();

		// No idling on either side
		idle_on = 1'b0;
		set_regs(200, 8, 4, 1);
		random_tunes(230);
		settle();
		idle_on = 1'b1;

		// Top octave with sharp B, spare articulation code
		set_regs(60, 16, 7, 3);
		send_text("B#", 1);
		random_tunes(230);
		settle();

		// Zero tempo and zero default length
		set_regs(0, 0, 2, 0);
		random_tunes(200);
		settle();

		set_regs($urandom_range(1, 255), $urandom_range(1, 64), $urandom_range(0, 6),
			$urandom_range(0, 2));
		random_tunes(230);
		settle();

		$display("Sent %0d tune characters over seven register settings;", chars_sent);
		$display("checked %0d command beats, %0d mismatches.", cmds_checked, fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
